// File: design/aip_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ASCII integer parser package
// Shared types and constants for the parser front end, token queue and
// accumulator back end.
// ----------------------------------------------------------------------------
package aip_pkg;

  // Target modes held in the mode register.
  localparam logic [2:0] MODE_INT8    = 3'd0;
  localparam logic [2:0] MODE_UINT8   = 3'd1;
  localparam logic [2:0] MODE_INT16   = 3'd2;
  localparam logic [2:0] MODE_UINT16  = 3'd3;
  localparam logic [2:0] MODE_HEX16   = 3'd4;
  localparam logic [2:0] MODE_UINT64  = 3'd5;

  // Character codes.
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_UP_A   = 8'h41;
  localparam logic [7:0] CHAR_UP_F   = 8'h46;
  localparam logic [7:0] CHAR_LOW_A  = 8'h61;
  localparam logic [7:0] CHAR_LOW_F  = 8'h66;
  localparam logic [3:0] HEX_LETTER_BASE = 4'd10;

  // Magnitude limits for the range check.
  localparam logic [63:0] LIM_I8_NEG  = 64'd128;
  localparam logic [63:0] LIM_I8_POS  = 64'd127;
  localparam logic [63:0] LIM_U8      = 64'd255;
  localparam logic [63:0] LIM_I16_NEG = 64'd32768;
  localparam logic [63:0] LIM_I16_POS = 64'd32767;
  localparam logic [63:0] LIM_U16     = 64'd65535;

  // Input item.
  typedef struct packed {
    logic [7:0] char_code;
    logic       char_present;
    logic       last_char;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [63:0] parsed_value;
    logic        parse_failed;
  } out_item_t;

  // Classified character as handed from the front end to the back end.
  typedef enum logic [1:0] {
    TOK_SKIP,
    TOK_NEG,
    TOK_BAD,
    TOK_DIGIT
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] digit;
    logic [2:0] mode;
    logic       last;
  } token_t;

endpackage : aip_pkg
`default_nettype wire

// File: design/ascii_integer_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ASCII integer parser
// Parses a decimal or hexadecimal string, one character per transfer, into
// an int8, uint8, int16, uint16 or uint64 value with an error flag.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while full is low, set by the shift-and-add
//   accumulator in the back end.
// Result path: a last character passes through the token queue, the finish stage
//   and the result queue, in that order, before it shows on the result ports.
// Reset: rst clears the queues, the string state and the mode register (int8).
module ascii_integer_parser #(
  parameter int TOKEN_DEPTH  = 4,
  parameter int RESULT_DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire aip_pkg::in_item_t  char_item,
  input  wire logic               push,
  output logic                    full,
  output aip_pkg::out_item_t      result,
  output logic                    empty,
  input  wire logic               pop,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_data
);

  import aip_pkg::*;

  localparam int TW = $bits(token_t);
  localparam int RW = $bits(out_item_t);

  logic [2:0]                        target_mode;
  logic                              tok_full;
  logic                              tok_empty;
  logic                              tok_push;
  logic                              tok_pop;
  token_t                            tok_in;
  logic [TW-1:0]                     tok_out_bits;
  token_t                            tok_out;
  logic [$clog2(TOKEN_DEPTH+1)-1:0]  tok_count;
  logic                              res_push;
  logic                              res_full;
  out_item_t                         res_item;
  logic [RW-1:0]                     res_out_bits;
  logic [$clog2(RESULT_DEPTH+1)-1:0] res_count;

  // Mode register; writes are always taken.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      target_mode <= MODE_INT8;
    end else if (cfg_valid && cfg_ready) begin
      target_mode <= cfg_data;
    end
  end

  // Front end: character classification.
  aip_front u_front (
    .clk       (clk),
    .rst       (rst),
    .char_item (char_item),
    .push      (push),
    .full      (full),
    .mode      (target_mode),
    .tok_full  (tok_full),
    .tok_push  (tok_push),
    .tok_data  (tok_in)
  );

  // Token queue between the two halves.
  aip_fifo #(
    .WIDTH (TW),
    .DEPTH (TOKEN_DEPTH)
  ) u_tok_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (tok_push),
    .wr_data (tok_in),
    .rd_en   (tok_pop),
    .rd_data (tok_out_bits),
    .full    (tok_full),
    .empty   (tok_empty),
    .count   (tok_count)
  );
  assign tok_out = token_t'(tok_out_bits);

  // Back end: accumulation and result formation.
  aip_back #(
    .RESULT_DEPTH (RESULT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_data  (tok_out),
    .tok_empty (tok_empty),
    .tok_pop   (tok_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res_item  (res_item)
  );

  // Result queue toward the consumer.
  aip_fifo #(
    .WIDTH (RW),
    .DEPTH (RESULT_DEPTH)
  ) u_res_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_item),
    .rd_en   (pop),
    .rd_data (res_out_bits),
    .full    (res_full),
    .empty   (empty),
    .count   (res_count)
  );
  assign result = out_item_t'(res_out_bits);

  // The credit check must keep the finish stage from ever meeting a full queue.
  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  // A last token always produces a result in the following cycle.
  a_last_finishes: assert property (@(posedge clk) disable iff (rst)
    (tok_pop && !tok_empty && tok_out.last) |=> res_push)
    else $error("last token produced no result");

  // A failed parse carries a zero value.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (res_push && res_item.parse_failed) |-> (res_item.parsed_value == 64'd0))
    else $error("failed result with nonzero value");

  // The token queue fill count stays within its depth.
  a_tok_count: assert property (@(posedge clk) disable iff (rst)
    tok_count <= ($clog2(TOKEN_DEPTH+1))'(TOKEN_DEPTH))
    else $error("token queue count out of range");

endmodule : ascii_integer_parser
`default_nettype wire

// File: design/aip_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Parser queue
// Small first-word-fall-through queue built from a register array, with a
// fill count for credit-based flow control.
// ----------------------------------------------------------------------------
module aip_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             wr_en,
  input  wire logic [WIDTH-1:0]                 wr_data,
  input  wire logic                             rd_en,
  output logic      [WIDTH-1:0]                 rd_data,
  output logic                                  full,
  output logic                                  empty,
  output logic      [$clog2(DEPTH+1)-1:0]       count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule : aip_fifo
`default_nettype wire

// File: design/aip_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Parser front end
// Accepts characters, tracks the start of each string and classifies every
// character into a sign, digit, bad or skip token for the back end.
// ----------------------------------------------------------------------------
module aip_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire aip_pkg::in_item_t char_item,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [2:0]        mode,
  input  wire logic              tok_full,
  output logic                   tok_push,
  output aip_pkg::token_t        tok_data
);

  import aip_pkg::*;

  logic       at_first_char;
  logic       accept;
  logic       signed_mode;
  logic       hex_mode;
  logic [7:0] c;
  logic [7:0] off_dec;
  logic [7:0] off_low;
  logic [7:0] off_up;
  logic       is_dec;
  logic       is_low;
  logic       is_up;

  assign full   = tok_full;
  assign accept = push && !tok_full;
  assign c      = char_item.char_code;

  assign signed_mode = (mode == MODE_INT8) || (mode == MODE_INT16);
  assign hex_mode    = (mode == MODE_HEX16);

  assign off_dec = c - CHAR_ZERO;
  assign off_low = c - CHAR_LOW_A;
  assign off_up  = c - CHAR_UP_A;
  assign is_dec  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  assign is_low  = hex_mode && (c >= CHAR_LOW_A) && (c <= CHAR_LOW_F);
  assign is_up   = hex_mode && (c >= CHAR_UP_A) && (c <= CHAR_UP_F);

  // Classify the character; an empty item only matters when it ends a string.
  always_comb begin
    tok_data.kind  = TOK_SKIP;
    tok_data.digit = '0;
    tok_data.mode  = mode;
    tok_data.last  = char_item.last_char;
    tok_push       = accept && (char_item.char_present || char_item.last_char);
    if (char_item.char_present) begin
      if (at_first_char && (c == CHAR_PLUS)) begin
        tok_data.kind = TOK_SKIP;
      end else if (at_first_char && (c == CHAR_MINUS)) begin
        tok_data.kind = signed_mode ? TOK_NEG : TOK_BAD;
      end else if (is_dec) begin
        tok_data.kind  = TOK_DIGIT;
        tok_data.digit = off_dec[3:0];
      end else if (is_low) begin
        tok_data.kind  = TOK_DIGIT;
        tok_data.digit = off_low[3:0] + HEX_LETTER_BASE;
      end else if (is_up) begin
        tok_data.kind  = TOK_DIGIT;
        tok_data.digit = off_up[3:0] + HEX_LETTER_BASE;
      end else begin
        tok_data.kind = TOK_BAD;
      end
    end
  end

  // Start-of-string flag: set after a last item, cleared by any character.
  always_ff @(posedge clk) begin
    if (rst) begin
      at_first_char <= 1'b1;
    end else if (accept) begin
      if (char_item.last_char) begin
        at_first_char <= 1'b1;
      end else if (char_item.char_present) begin
        at_first_char <= 1'b0;
      end
    end
  end

endmodule : aip_front
`default_nettype wire

// File: design/aip_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Parser back end
// Folds digit tokens into the running magnitude with overflow detection,
// then range-checks and signs the value in a finish stage.
// ----------------------------------------------------------------------------
module aip_back #(
  parameter int RESULT_DEPTH = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire aip_pkg::token_t                   tok_data,
  input  wire logic                              tok_empty,
  output logic                                   tok_pop,
  input  wire logic [$clog2(RESULT_DEPTH+1)-1:0] res_count,
  output logic                                   res_push,
  output aip_pkg::out_item_t                     res_item
);

  import aip_pkg::*;

  localparam int CW = $clog2(RESULT_DEPTH+1);

  // Running string state.
  logic [63:0] magnitude_acc;
  logic        overflow_seen;
  logic        is_negative;
  logic        digit_seen;
  logic        bad_seen;
  logic [63:0] magnitude_acc_next;
  logic        overflow_seen_next;
  logic        is_negative_next;
  logic        digit_seen_next;
  logic        bad_seen_next;

  // Finish stage.
  logic        fin_valid;
  logic [63:0] fin_mag;
  logic        fin_ovf;
  logic        fin_neg;
  logic        fin_digit;
  logic        fin_bad;
  logic [2:0]  fin_mode;

  logic [CW:0] slots_used;
  logic        credit;
  logic [67:0] scaled_sum;
  logic        in_range;
  logic        failed;

  // A last token needs a result slot reserved downstream.
  assign slots_used = {1'b0, res_count} + (CW+1)'(fin_valid);
  assign credit     = slots_used < (CW+1)'(RESULT_DEPTH);
  assign tok_pop    = !tok_empty && (!tok_data.last || credit);

  // Multiply by the base with shifts and add the digit, keeping carry-out bits.
  always_comb begin
    if (tok_data.mode == MODE_HEX16) begin
      scaled_sum = {magnitude_acc, 4'b0} + {64'b0, tok_data.digit};
    end else begin
      scaled_sum = {3'b0, magnitude_acc, 1'b0} + {1'b0, magnitude_acc, 3'b0}
                 + {64'b0, tok_data.digit};
    end
  end

  // Token update.
  always_comb begin
    magnitude_acc_next = magnitude_acc;
    overflow_seen_next = overflow_seen;
    is_negative_next   = is_negative;
    digit_seen_next    = digit_seen;
    bad_seen_next      = bad_seen;
    unique case (tok_data.kind)
      TOK_SKIP: begin
      end
      TOK_NEG: begin
        is_negative_next = 1'b1;
      end
      TOK_BAD: begin
        bad_seen_next = 1'b1;
      end
      TOK_DIGIT: begin
        digit_seen_next = 1'b1;
        if (!overflow_seen) begin
          if (scaled_sum[67:64] != 4'b0) begin
            overflow_seen_next = 1'b1;
          end else begin
            magnitude_acc_next = scaled_sum[63:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // String state registers; a last token hands its state to the finish stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude_acc <= '0;
      overflow_seen <= 1'b0;
      is_negative   <= 1'b0;
      digit_seen    <= 1'b0;
      bad_seen      <= 1'b0;
      fin_valid     <= 1'b0;
    end else begin
      fin_valid <= tok_pop && tok_data.last;
      if (tok_pop) begin
        if (tok_data.last) begin
          magnitude_acc <= '0;
          overflow_seen <= 1'b0;
          is_negative   <= 1'b0;
          digit_seen    <= 1'b0;
          bad_seen      <= 1'b0;
        end else begin
          magnitude_acc <= magnitude_acc_next;
          overflow_seen <= overflow_seen_next;
          is_negative   <= is_negative_next;
          digit_seen    <= digit_seen_next;
          bad_seen      <= bad_seen_next;
        end
      end
    end
  end

  // Finish stage payload.
  always_ff @(posedge clk) begin
    if (tok_pop && tok_data.last) begin
      fin_mag   <= magnitude_acc_next;
      fin_ovf   <= overflow_seen_next;
      fin_neg   <= is_negative_next;
      fin_digit <= digit_seen_next;
      fin_bad   <= bad_seen_next;
      fin_mode  <= tok_data.mode;
    end
  end

  // Range check for the mode in effect at the last item.
  always_comb begin
    unique case (fin_mode)
      MODE_INT8:   in_range = fin_neg ? (fin_mag <= LIM_I8_NEG) : (fin_mag <= LIM_I8_POS);
      MODE_UINT8:  in_range = fin_mag <= LIM_U8;
      MODE_INT16:  in_range = fin_neg ? (fin_mag <= LIM_I16_NEG) : (fin_mag <= LIM_I16_POS);
      MODE_UINT16: in_range = fin_mag <= LIM_U16;
      MODE_HEX16:  in_range = fin_mag <= LIM_U16;
      MODE_UINT64: in_range = 1'b1;
      default:     in_range = 1'b0;
    endcase
  end

  // Result formation: two's complement for negative values, zero on failure.
  assign failed   = fin_bad || !fin_digit || fin_ovf || !in_range;
  assign res_push = fin_valid;
  always_comb begin
    res_item.parse_failed = failed;
    if (failed) begin
      res_item.parsed_value = '0;
    end else if (fin_neg) begin
      res_item.parsed_value = 64'd0 - fin_mag;
    end else begin
      res_item.parsed_value = fin_mag;
    end
  end

endmodule : aip_back
`default_nettype wire
